### rtl/gf256_word_poly_inverse_macros.svh
// Assertion helpers used by the checker file.
`ifndef GF256_WORD_POLY_INVERSE_MACROS_SVH
`define GF256_WORD_POLY_INVERSE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define GWPI_ASSERT_SAME(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("gwpi check failed");

// Next-cycle implication, checked outside reset.
`define GWPI_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("gwpi check failed");

`endif

### rtl/gwpi_pkg.sv
`default_nettype none
package gwpi_pkg;

  typedef logic [7:0] gf_t;
  // Remainder row: index j is column j of the Euclid table.
  typedef gf_t [4:0] rem_t;
  typedef gf_t [3:0] aux_t;

  // Per-round carried state: two latest remainders and auxiliaries.
  typedef struct packed {
    rem_t rem_a;
    rem_t rem_b;
    aux_t aux_a;
    aux_t aux_b;
    logic ok;
  } round_t;

  // Working set inside one round.
  typedef struct packed {
    round_t st;
    gf_t    inv;
    gf_t    q2;
    gf_t    q3;
    rem_t   tmp;
  } work_t;

  localparam gf_t GF_POLY = 8'h1b;
  localparam gf_t GF_ONE  = 8'h01;
  localparam gf_t GF_ZERO = 8'h00;

  localparam gf_t INV_TBL [0:255] = '{
    8'h00,8'h01,8'h8d,8'hf6,8'hcb,8'h52,8'h7b,8'hd1,8'he8,8'h4f,8'h29,8'hc0,8'hb0,8'he1,8'he5,8'hc7,
    8'h74,8'hb4,8'haa,8'h4b,8'h99,8'h2b,8'h60,8'h5f,8'h58,8'h3f,8'hfd,8'hcc,8'hff,8'h40,8'hee,8'hb2,
    8'h3a,8'h6e,8'h5a,8'hf1,8'h55,8'h4d,8'ha8,8'hc9,8'hc1,8'h0a,8'h98,8'h15,8'h30,8'h44,8'ha2,8'hc2,
    8'h2c,8'h45,8'h92,8'h6c,8'hf3,8'h39,8'h66,8'h42,8'hf2,8'h35,8'h20,8'h6f,8'h77,8'hbb,8'h59,8'h19,
    8'h1d,8'hfe,8'h37,8'h67,8'h2d,8'h31,8'hf5,8'h69,8'ha7,8'h64,8'hab,8'h13,8'h54,8'h25,8'he9,8'h09,
    8'hed,8'h5c,8'h05,8'hca,8'h4c,8'h24,8'h87,8'hbf,8'h18,8'h3e,8'h22,8'hf0,8'h51,8'hec,8'h61,8'h17,
    8'h16,8'h5e,8'haf,8'hd3,8'h49,8'ha6,8'h36,8'h43,8'hf4,8'h47,8'h91,8'hdf,8'h33,8'h93,8'h21,8'h3b,
    8'h79,8'hb7,8'h97,8'h85,8'h10,8'hb5,8'hba,8'h3c,8'hb6,8'h70,8'hd0,8'h06,8'ha1,8'hfa,8'h81,8'h82,
    8'h83,8'h7e,8'h7f,8'h80,8'h96,8'h73,8'hbe,8'h56,8'h9b,8'h9e,8'h95,8'hd9,8'hf7,8'h02,8'hb9,8'ha4,
    8'hde,8'h6a,8'h32,8'h6d,8'hd8,8'h8a,8'h84,8'h72,8'h2a,8'h14,8'h9f,8'h88,8'hf9,8'hdc,8'h89,8'h9a,
    8'hfb,8'h7c,8'h2e,8'hc3,8'h8f,8'hb8,8'h65,8'h48,8'h26,8'hc8,8'h12,8'h4a,8'hce,8'he7,8'hd2,8'h62,
    8'h0c,8'he0,8'h1f,8'hef,8'h11,8'h75,8'h78,8'h71,8'ha5,8'h8e,8'h76,8'h3d,8'hbd,8'hbc,8'h86,8'h57,
    8'h0b,8'h28,8'h2f,8'ha3,8'hda,8'hd4,8'he4,8'h0f,8'ha9,8'h27,8'h53,8'h04,8'h1b,8'hfc,8'hac,8'he6,
    8'h7a,8'h07,8'hae,8'h63,8'hc5,8'hdb,8'he2,8'hea,8'h94,8'h8b,8'hc4,8'hd5,8'h9d,8'hf8,8'h90,8'h6b,
    8'hb1,8'h0d,8'hd6,8'heb,8'hc6,8'h0e,8'hcf,8'had,8'h08,8'h4e,8'hd7,8'he3,8'h5d,8'h50,8'h1e,8'hb3,
    8'h5b,8'h23,8'h38,8'h34,8'h68,8'h46,8'h03,8'h8c,8'hdd,8'h9c,8'h7d,8'ha0,8'hcd,8'h1a,8'h41,8'h1c
  };

  // Product in GF(2^8) modulo x^8+x^4+x^3+x+1.
  function automatic gf_t gf_mul(input gf_t a, input gf_t b);
    gf_t acc;
    gf_t x;
    acc = GF_ZERO;
    x   = a;
    for (int k = 0; k < 8; k++) begin
      if (b[k]) acc = acc ^ x;
      x = {x[6:0], 1'b0} ^ (x[7] ? GF_POLY : GF_ZERO);
    end
    return acc;
  endfunction

endpackage
`default_nettype wire

### rtl/gwpi_round.sv
`default_nettype none
// One Euclid round in four register stages:
// inverse and first quotient term, partial remainder, second quotient term,
// then new remainder and auxiliary.
module gwpi_round
  import gwpi_pkg::*;
#(
  parameter int unsigned RND = 2
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         in_valid,
  output logic        in_ready,
  input  wire round_t in_data,
  output logic        out_valid,
  input  wire         out_ready,
  output round_t      out_data
);

  logic [3:0] vld;
  logic [3:0] rdy;
  work_t      w1, w2, w3;
  work_t      w1_next, w2_next, w3_next;
  round_t     w4, w4_next;
  gf_t        tmp_b [5];
  gf_t        rem_n [5];
  aux_t       aux_n;
  logic       ok_n;

  // A stage may load when empty or when its content moves on
  assign rdy[3]   = !vld[3] || out_ready;
  assign rdy[2]   = !vld[2] || rdy[3];
  assign rdy[1]   = !vld[1] || rdy[2];
  assign rdy[0]   = !vld[0] || rdy[1];
  assign in_ready = rdy[0];

  // Stage A: inverse of the leading coefficient and first quotient term
  always_comb begin
    w1_next     = '0;
    w1_next.st  = in_data;
    w1_next.inv = INV_TBL[in_data.rem_b[RND-1]];
    w1_next.q2  = gf_mul(w1_next.inv, in_data.rem_a[RND-2]);
  end

  // Stage B: partial remainder after the first quotient term
  for (genvar j = 0; j < 5; j++) begin : g_tmp
    if (j < 5 - RND) begin : g_mix
      assign tmp_b[j] = w1.st.rem_a[j+RND-1] ^ gf_mul(w1.st.rem_b[j+RND], w1.q2);
    end else if (j == 5 - RND) begin : g_top
      assign tmp_b[j] = w1.st.rem_a[4];
    end else begin : g_zero
      assign tmp_b[j] = GF_ZERO;
    end
  end

  always_comb begin
    w2_next = w1;
    for (int j = 0; j < 5; j++) w2_next.tmp[j] = tmp_b[j];
  end

  // Stage C: second quotient term; the last round folds in the constant one
  always_comb begin
    w3_next    = w2;
    w3_next.q3 = gf_mul(w2.inv, w2.tmp[0] ^ ((RND == 5) ? GF_ONE : GF_ZERO));
  end

  // Stage D: new remainder
  for (genvar j = 0; j < 5; j++) begin : g_rem
    if (RND == 5 && j == 4) begin : g_one
      assign rem_n[j] = GF_ONE;
    end else if (j < RND) begin : g_zero
      assign rem_n[j] = GF_ZERO;
    end else begin : g_upd
      assign rem_n[j] = w3.tmp[j-RND+1] ^ gf_mul(w3.st.rem_b[j], w3.q3);
    end
  end

  // Flag a zero leading coefficient of the new remainder
  if (RND < 5) begin : g_chk
    assign ok_n = w3.st.ok && (rem_n[RND] != GF_ZERO);
  end else begin : g_nochk
    assign ok_n = w3.st.ok;
  end

  // Stage D: quotient times previous auxiliary modulo x^4+1, plus older auxiliary
  always_comb begin
    gf_t quo [4];
    gf_t s;
    quo[0] = GF_ZERO;
    quo[1] = GF_ZERO;
    quo[2] = w3.q2;
    quo[3] = w3.q3;
    for (int j = 0; j < 4; j++) begin
      s = w3.st.aux_a[j];
      for (int k = 0; k < 4; k++) s = s ^ gf_mul(quo[2'(j + k)], w3.st.aux_b[2'(3 - k)]);
      aux_n[j] = s;
    end
  end

  always_comb begin
    w4_next.rem_a = w3.st.rem_b;
    for (int j = 0; j < 5; j++) w4_next.rem_b[j] = rem_n[j];
    w4_next.aux_a = w3.st.aux_b;
    w4_next.aux_b = aux_n;
    w4_next.ok    = ok_n;
  end

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) vld[0] <= in_valid;
      if (rdy[1]) vld[1] <= vld[0];
      if (rdy[2]) vld[2] <= vld[1];
      if (rdy[3]) vld[3] <= vld[2];
    end
  end

  // Advance payload
  always_ff @(posedge clk) begin
    if (rdy[0]) w1 <= w1_next;
    if (rdy[1]) w2 <= w2_next;
    if (rdy[2]) w3 <= w3_next;
    if (rdy[3]) w4 <= w4_next;
  end

  assign out_valid = vld[3];
  assign out_data  = w4;

endmodule
`default_nettype wire

### rtl/gf256_word_poly_inverse.sv
// Inverse of a word polynomial a3*x^3+a2*x^2+a1*x+a0 over GF(2^8), modulo x^4+1.
// Input beat (s_*): s_tdata carries the polynomial, a3 in bits 31:24 down to a0.
// Output beat (m_*): m_tdata carries the inverse in the same byte order and
// m_tuser is high when the inverse exists; otherwise m_tdata is zero.
// Exactly one output beat per input beat, in order.
// Pipeline: four Euclid rounds of four stages each, plus the output register.
// Throughput: one beat per cycle while m_tready stays high; every stage is its
// own register, so a new word can enter each cycle unless the pipeline is stalled.
// Reset clears all valid bits; words in flight are dropped.
// When the receiver holds m_tready low, the output holds and the pipeline
// keeps filling empty stages; s_tready drops only once all stages are full.
`default_nettype none
module gf256_word_poly_inverse
  import gwpi_pkg::*;
(
  input  wire         clk,
  input  wire         rst,
  input  wire         s_tvalid,
  output logic        s_tready,
  input  wire  [31:0] s_tdata,   // [31:0] poly_word
  output logic        m_tvalid,
  input  wire         m_tready,
  output logic [31:0] m_tdata,   // [31:0] inverse_word
  output logic        m_tuser    // [0] has_inverse
);

  round_t     rd [5];
  logic [4:0] rv;
  logic [4:0] rr;

  // Seed rows: x^4+1 and the input word; auxiliary starts at 0 and 1
  always_comb begin
    rd[0].rem_a    = '0;
    rd[0].rem_a[0] = GF_ONE;
    rd[0].rem_a[4] = GF_ONE;
    rd[0].rem_b[0] = GF_ZERO;
    rd[0].rem_b[1] = s_tdata[31:24];
    rd[0].rem_b[2] = s_tdata[23:16];
    rd[0].rem_b[3] = s_tdata[15:8];
    rd[0].rem_b[4] = s_tdata[7:0];
    rd[0].aux_a    = '0;
    rd[0].aux_b    = '0;
    rd[0].aux_b[3] = GF_ONE;
    rd[0].ok       = (s_tdata[31:24] != GF_ZERO);
  end

  assign rv[0]    = s_tvalid;
  assign s_tready = rr[0];

  // Four Euclid rounds
  for (genvar r = 0; r < 4; r++) begin : g_round
    gwpi_round #(
      .RND (r + 2)
    ) u_round (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (rv[r]),
      .in_ready  (rr[r]),
      .in_data   (rd[r]),
      .out_valid (rv[r+1]),
      .out_ready (rr[r+1]),
      .out_data  (rd[r+1])
    );
  end

  // Output register
  assign rr[4] = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (rr[4]) begin
      m_tvalid <= rv[4];
    end
  end

  // Load result; zero the word when no inverse exists
  always_ff @(posedge clk) begin
    if (rr[4] && rv[4]) begin
      m_tdata <= rd[4].ok ? {rd[4].aux_b[0], rd[4].aux_b[1], rd[4].aux_b[2], rd[4].aux_b[3]}
                          : 32'h0;
      m_tuser <= rd[4].ok;
    end
  end

endmodule
`default_nettype wire

### rtl/gwpi_checker.sv
`default_nettype none
`include "gf256_word_poly_inverse_macros.svh"
module gwpi_checker (
  input wire        clk,
  input wire        rst,
  input wire        s_tready,
  input wire        m_tvalid,
  input wire        m_tready,
  input wire [31:0] m_tdata,
  input wire        m_tuser
);

  // Stalled output beat holds
  `GWPI_ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

  // No inverse means a zero word
  `GWPI_ASSERT_SAME(a_zero_word, clk, rst, m_tvalid && !m_tuser, m_tdata == 32'h0)

  // A ready sink lets the whole pipeline move
  `GWPI_ASSERT_SAME(a_ready_chain, clk, rst, m_tready, s_tready)

  // Nothing leaves right after reset
  `GWPI_ASSERT_SAME(a_reset_empty, clk, rst, $past(rst), !m_tvalid)

endmodule

bind gf256_word_poly_inverse gwpi_checker u_gwpi_checker (.*);
`default_nettype wire

### test/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import gwpi_pkg::gf_t;

  // One predicted result beat.
  typedef struct packed {
    logic [31:0] inverse_word;
    logic        has_inverse;
  } inverse_result_t;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic [31:0] s_tdata  = '0;
  logic        m_tready = 1'b0;
  wire         s_tready;
  wire         m_tvalid;
  wire  [31:0] m_tdata;
  wire         m_tuser;

  gf_t             gf_recip [0:255];
  logic [31:0]     words_to_send [$];
  inverse_result_t pending_inverses [$];
  int unsigned     mismatches      = 0;
  int unsigned     sender_idle_pct = 0;
  int unsigned     ready_stall_pct = 0;
  logic            sender_hold     = 1'b0;
  logic            hold_trigger    = 1'b0;
  logic            long_hold       = 1'b0;
  logic            in_taken        = 1'b0;

  gf256_word_poly_inverse dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shift-and-add product in GF(2^8), reduced by x^8+x^4+x^3+x+1.
  function automatic gf_t gf_times(input gf_t a, input gf_t b);
    logic [8:0] x;
    gf_t        acc;
    acc = 8'h00;
    x   = {1'b0, a};
    for (int k = 0; k < 8; k++) begin
      if (b[k]) acc = acc ^ x[7:0];
      x = x << 1;
      if (x[8]) x = x ^ 9'h11b;
    end
    return acc;
  endfunction

  // Run the four Euclid rounds against x^4+1 and form the expected beat.
  function automatic inverse_result_t poly_inverse_predict(input logic [31:0] word);
    gf_t             rem [0:5][0:4];
    gf_t             quo [0:5][0:3];
    gf_t             aux [0:5][0:3];
    gf_t             tmp [0:4];
    gf_t             lead_inv;
    gf_t             hi;
    gf_t             s;
    logic            ok;
    inverse_result_t r;
    for (int i = 0; i < 6; i++) begin
      for (int j = 0; j < 5; j++) rem[i][j] = 8'h00;
      for (int j = 0; j < 4; j++) begin
        quo[i][j] = 8'h00;
        aux[i][j] = 8'h00;
      end
    end
    rem[0][0] = 8'h01;
    rem[0][4] = 8'h01;
    for (int j = 0; j < 4; j++) rem[1][j + 1] = word[24 - 8 * j +: 8];
    aux[1][3] = 8'h01;
    ok = (rem[1][1] != 8'h00);

    for (int i = 2; i < 6; i++) begin
      lead_inv = gf_recip[rem[i - 1][i - 1]];
      for (int j = 0; j < 5; j++) tmp[j] = 8'h00;
      quo[i][2] = gf_times(lead_inv, rem[i - 2][i - 2]);
      // first division step: one place past the top reads as zero
      for (int j = 0; j < 6 - i; j++) begin
        hi = 8'h00;
        if (j + i < 5) hi = rem[i - 1][j + i];
        tmp[j] = rem[i - 2][j + i - 1] ^ gf_times(hi, quo[i][2]);
      end
      if (i < 5) begin
        tmp[5 - i] = rem[i - 2][4];
        quo[i][3]  = gf_times(lead_inv, tmp[0]);
      end else begin
        quo[i][3] = gf_times(lead_inv, tmp[0] ^ 8'h01);
        rem[i][4] = 8'h01;
      end
      for (int j = i; j < 5; j++)
        rem[i][j] = tmp[j - i + 1] ^ gf_times(rem[i - 1][j], quo[i][3]);
      // quotient times previous auxiliary, modulo x^4+1
      for (int j = 0; j < 4; j++) begin
        s = 8'h00;
        for (int k = 0; k < 4; k++)
          s = s ^ gf_times(quo[i][(j + k) & 3], aux[i - 1][(3 - k) & 3]);
        aux[i][j] = s ^ aux[i - 2][j];
      end
      if (i != 5 && rem[i][i] == 8'h00) ok = 1'b0;
    end

    if (ok) begin
      r.inverse_word = {aux[5][0], aux[5][1], aux[5][2], aux[5][3]};
      r.has_inverse  = 1'b1;
    end else begin
      r.inverse_word = '0;
      r.has_inverse  = 1'b0;
    end
    return r;
  endfunction

  // Bias toward zero, one and all-ones bytes.
  function automatic gf_t pick_byte();
    case ($urandom_range(5))
      0: return 8'h00;
      1: return 8'h01;
      2: return 8'hff;
      default: return gf_t'($urandom_range(255));
    endcase
  endfunction

  function automatic logic [31:0] random_poly();
    if ($urandom_range(1) == 1) return $urandom;
    return {pick_byte(), pick_byte(), pick_byte(), pick_byte()};
  endfunction

  // Driver: offer a new beat once the previous one was taken.
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || in_taken) begin
      if (!sender_hold && words_to_send.size() != 0 &&
          $urandom_range(99) >= sender_idle_pct) begin
        s_tdata  <= words_to_send.pop_front();
        s_tvalid <= 1'b1;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls plus the long hold-off.
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= !long_hold && ($urandom_range(99) >= ready_stall_pct);
    end
  end

  // Hold off the receiver long enough to fill the pipeline and stall the input.
  initial begin
    while (!hold_trigger) @(negedge clk);
    long_hold <= 1'b1;
    repeat (300) @(negedge clk);
    long_hold <= 1'b0;
  end

  // Monitor: check result beats, then log accepted input beats.
  always @(posedge clk) begin : monitor
    inverse_result_t want;
    if (rst) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= s_tvalid && s_tready;
      if (m_tvalid && m_tready) begin
        if (pending_inverses.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result beat: inverse %h flag %b", m_tdata, m_tuser);
        end else begin
          want = pending_inverses.pop_front();
          if (m_tdata !== want.inverse_word || m_tuser !== want.has_inverse) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected inverse %h flag %b, got inverse %h flag %b",
                       want.inverse_word, want.has_inverse, m_tdata, m_tuser);
          end
        end
      end
      if (s_tvalid && s_tready) pending_inverses.push_back(poly_inverse_predict(s_tdata));
    end
  end

  task automatic drain_input();
    while (words_to_send.size() != 0 || s_tvalid) @(posedge clk);
  endtask

  task automatic wait_results();
    while (s_tvalid || pending_inverses.size() != 0) @(posedge clk);
  endtask

  // Stimulus sequence.
  initial begin
    logic [31:0]     w;
    inverse_result_t probe;
    int              found;
    int              tries;

    // byte reciprocal table by search; zero maps to zero
    gf_recip[0] = 8'h00;
    for (int a = 1; a < 256; a++)
      for (int b = 1; b < 256; b++)
        if (gf_times(gf_t'(a), gf_t'(b)) == 8'h01) gf_recip[a] = gf_t'(b);

    // extremes, top coefficient zero, known pairs
    words_to_send.push_back(32'h0000_0000);
    words_to_send.push_back(32'hffff_ffff);
    words_to_send.push_back(32'h0000_0001);
    words_to_send.push_back(32'h00ff_ffff);
    words_to_send.push_back(32'h0100_0000);
    words_to_send.push_back(32'hff00_0000);
    words_to_send.push_back(32'h8000_0000);
    words_to_send.push_back(32'h0100_0001);
    words_to_send.push_back(32'h0100_00ff);
    words_to_send.push_back(32'h0101_0101);
    words_to_send.push_back(32'h0301_0102);
    words_to_send.push_back(32'h0b0d_090e);
    words_to_send.push_back(32'h7f7f_7f7f);
    words_to_send.push_back(32'h8080_8080);
    words_to_send.push_back(32'h5555_aaaa);
    words_to_send.push_back(32'haaaa_5555);
    words_to_send.push_back(32'h0102_0408);

    // top coefficient nonzero but a later leading remainder coefficient zero
    found = 0;
    tries = 0;
    while (found < 4 && tries < 20000) begin
      w     = random_poly();
      probe = poly_inverse_predict(w);
      if (w[31:24] != 8'h00 && !probe.has_inverse) begin
        words_to_send.push_back(w);
        found++;
      end
      tries++;
    end

    repeat (4) @(negedge clk);
    rst <= 1'b0;

    // send all directed words, then wait until every result is back
    drain_input();
    wait_results();

    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin sender_idle_pct = 0;  ready_stall_pct = 0;  end
        1: begin sender_idle_pct = 60; ready_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  ready_stall_pct = 60; end
        default: begin sender_idle_pct = 14; ready_stall_pct = 14; end
      endcase
      for (int n = 0; n < 500; n++) words_to_send.push_back(random_poly());
      if (p == 0) hold_trigger = 1'b1;
      if (p == 2) begin
        while (words_to_send.size() > 250) @(posedge clk);
        sender_hold = 1'b1;
        wait_results();
        sender_hold = 1'b0;
      end
      drain_input();
    end

    wait_results();
    repeat (40) @(posedge clk);
    if (mismatches == 0 && pending_inverses.size() == 0) begin
      $display("gf256_word_poly_inverse test passed");
    end else begin
      $display("gf256_word_poly_inverse test failed");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #2000000;
    $display("gf256_word_poly_inverse test failed");
    $finish;
  end

endmodule
